@@ design/csi_kmd_pkg.sv @@
// ----------------------------------------------------------------------------
// csi_kmd_pkg
// Shared constants, types and lookup functions for the CSI key/mouse decoder.
// ----------------------------------------------------------------------------
package csi_kmd_pkg;

  localparam int unsigned KEPT_PARAMS = 3;
  localparam int unsigned CNT_W       = $clog2(KEPT_PARAMS + 1);
  localparam int unsigned IDX_W       = $clog2(KEPT_PARAMS);
  localparam int unsigned PARAM_W     = 31;

  // byte codes
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_UP_M  = 8'h4D;
  localparam logic [7:0] CH_LO_M  = 8'h6D;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] BTN_MOD_MASK = 8'h3C;

  typedef enum logic [1:0] {
    PFX_NONE  = 2'd0,
    PFX_LT    = 2'd1,
    PFX_QUEST = 2'd2,
    PFX_GT    = 2'd3
  } prefix_e;

  localparam logic [4:0] KEY_UNKNOWN = 5'd0;
  localparam logic [4:0] KEY_UP      = 5'd1;
  localparam logic [4:0] KEY_DOWN    = 5'd2;
  localparam logic [4:0] KEY_RIGHT   = 5'd3;
  localparam logic [4:0] KEY_LEFT    = 5'd4;
  localparam logic [4:0] KEY_HOME    = 5'd5;
  localparam logic [4:0] KEY_END     = 5'd6;
  localparam logic [4:0] KEY_INSERT  = 5'd7;
  localparam logic [4:0] KEY_DELETE  = 5'd8;
  localparam logic [4:0] KEY_PGUP    = 5'd9;
  localparam logic [4:0] KEY_PGDN    = 5'd10;
  localparam logic [4:0] KEY_F1      = 5'd11;

  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_DRAG    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic EV_KEY   = 1'b0;
  localparam logic EV_MOUSE = 1'b1;

  // committed parameter view handed from the collector to the decoder
  typedef struct packed {
    logic [KEPT_PARAMS-1:0][PARAM_W-1:0] value;
    logic [CNT_W-1:0]                    count;
    prefix_e                             prefix;
  } body_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  key_code;
    logic [3:0]  mods;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  button;
    logic [1:0]  action;
  } event_t;

  function automatic logic is_param_byte(input logic [7:0] c);
    return c[7:4] == 4'h3;
  endfunction

  function automatic logic is_final_byte(input logic [7:0] c);
    return (c >= 8'h40) && (c <= CH_TILDE);
  endfunction

  // tilde key number to key code
  function automatic logic [4:0] tilde_key(input logic [4:0] p);
    logic [4:0] k;
    case (p)
      5'd1:    k = KEY_HOME;
      5'd2:    k = KEY_INSERT;
      5'd3:    k = KEY_DELETE;
      5'd4:    k = KEY_END;
      5'd5:    k = KEY_PGUP;
      5'd6:    k = KEY_PGDN;
      5'd7:    k = KEY_HOME;
      5'd8:    k = KEY_END;
      5'd11:   k = KEY_F1;
      5'd12:   k = KEY_F1 + 5'd1;
      5'd13:   k = KEY_F1 + 5'd2;
      5'd14:   k = KEY_F1 + 5'd3;
      5'd15:   k = KEY_F1 + 5'd4;
      5'd17:   k = KEY_F1 + 5'd5;
      5'd18:   k = KEY_F1 + 5'd6;
      5'd19:   k = KEY_F1 + 5'd7;
      5'd20:   k = KEY_F1 + 5'd8;
      5'd21:   k = KEY_F1 + 5'd9;
      5'd23:   k = KEY_F1 + 5'd10;
      5'd24:   k = KEY_F1 + 5'd11;
      default: k = KEY_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

@@ design/csi_kmd_collect.sv @@
// ----------------------------------------------------------------------------
// csi_kmd_collect
// Parameter collector: prefix mark, field accumulator and kept parameters.
// ----------------------------------------------------------------------------
module csi_kmd_collect import csi_kmd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       first_i,
  output body_t      body_o
);

  typedef enum logic [1:0] {
    FS_EMPTY  = 2'd0,
    FS_DIGITS = 2'd1,
    FS_DONE   = 2'd2,
    FS_BAD    = 2'd3
  } field_st_e;

  logic [KEPT_PARAMS-1:0][PARAM_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]                    cnt_q, cnt_d;
  logic [PARAM_W-1:0]                  acc_q, acc_d;
  field_st_e                           st_q, st_d;
  prefix_e                             pre_q, pre_d;
  logic                                ne_q, ne_d;

  always_comb begin
    logic [KEPT_PARAMS-1:0][PARAM_W-1:0] val_b;
    logic [CNT_W-1:0]                    cnt_b;
    logic [PARAM_W-1:0]                  acc_b;
    field_st_e                           st_b;
    prefix_e                             pre_b;
    logic                                ne_b;
    logic [PARAM_W-1:0]                  fval;
    logic                                room;
    logic [34:0]                         prod;

    // clear the collection on the first word of a body
    val_b = first_i ? '0 : val_q;
    cnt_b = first_i ? '0 : cnt_q;
    acc_b = first_i ? '0 : acc_q;
    st_b  = first_i ? FS_EMPTY : st_q;
    pre_b = first_i ? PFX_NONE : pre_q;
    ne_b  = first_i ? 1'b0 : ne_q;

    fval = (st_b == FS_DIGITS || st_b == FS_DONE) ? acc_b : '0;
    room = cnt_b < CNT_W'(KEPT_PARAMS);
    prod = ({4'b0, acc_b} << 3) + ({4'b0, acc_b} << 1) + {31'b0, byte_i[3:0]};

    // committed view for the final byte
    body_o.value  = val_b;
    body_o.count  = cnt_b;
    body_o.prefix = pre_b;
    if (ne_b && room) begin
      body_o.value[cnt_b[IDX_W-1:0]] = fval;
      body_o.count = CNT_W'(cnt_b + 1'b1);
    end

    val_d = val_b;
    cnt_d = cnt_b;
    acc_d = acc_b;
    st_d  = st_b;
    pre_d = pre_b;
    ne_d  = ne_b;

    if (is_param_byte(byte_i)) begin
      ne_d = 1'b1;
      if (!ne_b && byte_i == CH_LT) begin
        pre_d = PFX_LT;
      end else if (!ne_b && byte_i == CH_QUEST) begin
        pre_d = PFX_QUEST;
      end else if (!ne_b && byte_i == CH_GT) begin
        pre_d = PFX_GT;
      end else if (byte_i == CH_SEMI) begin
        if (room) begin
          val_d[cnt_b[IDX_W-1:0]] = fval;
          cnt_d = CNT_W'(cnt_b + 1'b1);
        end
        acc_d = '0;
        st_d  = FS_EMPTY;
      end else if (byte_i[3:0] <= 4'd9) begin
        if (st_b == FS_EMPTY) begin
          acc_d = PARAM_W'(byte_i[3:0]);
          st_d  = FS_DIGITS;
        end else if (st_b == FS_DIGITS) begin
          if (|prod[34:31]) begin
            acc_d = '0;
            st_d  = FS_BAD;
          end else begin
            acc_d = prod[30:0];
          end
        end
      end else begin
        if (st_b == FS_EMPTY) begin
          st_d = FS_BAD;
        end else if (st_b == FS_DIGITS) begin
          st_d = FS_DONE;
        end
      end
    end else if (is_final_byte(byte_i)) begin
      val_d = '0;
      cnt_d = '0;
      acc_d = '0;
      st_d  = FS_EMPTY;
      pre_d = PFX_NONE;
      ne_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      cnt_q <= '0;
      acc_q <= '0;
      st_q  <= FS_EMPTY;
      pre_q <= PFX_NONE;
      ne_q  <= 1'b0;
    end else if (step_i) begin
      val_q <= val_d;
      cnt_q <= cnt_d;
      acc_q <= acc_d;
      st_q  <= st_d;
      pre_q <= pre_d;
      ne_q  <= ne_d;
    end
  end

endmodule

@@ design/csi_kmd_decode.sv @@
// ----------------------------------------------------------------------------
// csi_kmd_decode
// Maps the final byte and committed parameters to a key or mouse event.
// ----------------------------------------------------------------------------
module csi_kmd_decode import csi_kmd_pkg::*; (
  input  logic [7:0] final_i,
  input  body_t      body_i,
  output event_t     event_o
);

  logic [PARAM_W-1:0] p0, p1, p2;
  logic [3:0]         key_mods;
  logic               is_mouse;

  assign p0 = body_i.value[0];
  assign p1 = body_i.value[1];
  assign p2 = body_i.value[2];

  assign key_mods = (body_i.count >= CNT_W'(2) && p1 > PARAM_W'(1))
                    ? 4'(p1 - PARAM_W'(1)) : 4'd0;

  assign is_mouse = (body_i.prefix == PFX_LT) && (final_i == CH_UP_M || final_i == CH_LO_M)
                    && (body_i.count >= CNT_W'(3));

  always_comb begin
    event_o = '0;
    if (is_mouse) begin
      event_o.kind   = EV_MOUSE;
      event_o.mods   = {1'b0, p0[4], p0[3], p0[2]};
      event_o.x      = (p1 != '0) ? 16'(p1 - PARAM_W'(1)) : 16'd0;
      event_o.y      = (p2 != '0) ? 16'(p2 - PARAM_W'(1)) : 16'd0;
      event_o.button = p0[7:0] & ~BTN_MOD_MASK;
      event_o.action = (final_i == CH_LO_M) ? ACT_RELEASE : (p0[5] ? ACT_DRAG : ACT_PRESS);
    end else if (final_i >= CH_A && final_i <= CH_H) begin
      event_o.mods = key_mods;
      case (final_i)
        CH_A:    event_o.key_code = KEY_UP;
        CH_B:    event_o.key_code = KEY_DOWN;
        CH_C:    event_o.key_code = KEY_RIGHT;
        CH_D:    event_o.key_code = KEY_LEFT;
        CH_H:    event_o.key_code = KEY_HOME;
        CH_F:    event_o.key_code = KEY_END;
        default: event_o.key_code = KEY_UNKNOWN;
      endcase
    end else if (final_i == CH_TILDE && body_i.count != '0) begin
      event_o.mods     = key_mods;
      event_o.key_code = (p0 < PARAM_W'(25)) ? tilde_key(p0[4:0]) : KEY_UNKNOWN;
    end
  end

endmodule

@@ design/csi_key_mouse_decoder.sv @@
// ----------------------------------------------------------------------------
// csi_key_mouse_decoder
// Decodes xterm CSI bodies into special-key and SGR mouse events.
// ----------------------------------------------------------------------------
// Path: events are decoded from the input register into the event register.
// Throughput: one byte per cycle unless a final byte is held; the input and
//   event registers let a new byte in while an event waits at the output.
// Reset: rst_ni clears all valid flags and the collected parameters; the
//   block is ready for bytes as soon as reset is released.
module csi_key_mouse_decoder import csi_kmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  body_byte_i,
  input  logic        first_of_body_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        event_kind_o,
  output logic [4:0]  key_code_o,
  output logic [3:0]  modifier_bits_o,
  output logic [15:0] mouse_x_o,
  output logic [15:0] mouse_y_o,
  output logic [7:0]  mouse_button_o,
  output logic [1:0]  mouse_action_o
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_first_q;
  logic       s1_final;
  logic       s1_go;
  logic       out_valid_q;
  event_t     ev_d, ev_q;
  body_t      body;

  assign s1_final   = is_final_byte(s1_byte_q);
  // hold a final byte while the event register is full and not draining
  assign s1_go      = s1_valid_q && (!s1_final || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q  <= body_byte_i;
      s1_first_q <= first_of_body_i;
    end
  end

  csi_kmd_collect u_collect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_go),
    .byte_i  (s1_byte_q),
    .first_i (s1_first_q),
    .body_o  (body)
  );

  csi_kmd_decode u_decode (
    .final_i (s1_byte_q),
    .body_i  (body),
    .event_o (ev_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_final) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_final) begin
      ev_q <= ev_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = ev_q.kind;
  assign key_code_o      = ev_q.key_code;
  assign modifier_bits_o = ev_q.mods;
  assign mouse_x_o       = ev_q.x;
  assign mouse_y_o       = ev_q.y;
  assign mouse_button_o  = ev_q.button;
  assign mouse_action_o  = ev_q.action;

endmodule

@@ design/csi_kmd_checker.sv @@
// ----------------------------------------------------------------------------
// csi_kmd_checker
// Port-level checks on the event channel of the CSI key/mouse decoder.
// ----------------------------------------------------------------------------
module csi_kmd_checker import csi_kmd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        event_kind_o,
  input logic [4:0]  key_code_o,
  input logic [3:0]  modifier_bits_o,
  input logic [15:0] mouse_x_o,
  input logic [15:0] mouse_y_o,
  input logic [7:0]  mouse_button_o,
  input logic [1:0]  mouse_action_o
);

  // a pending word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_code_o)
    && $stable(mouse_x_o) && $stable(mouse_action_o))
    else $error("event word dropped or changed while stalled");

  a_mouse_no_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EV_MOUSE |-> key_code_o == KEY_UNKNOWN
    && !modifier_bits_o[3] && mouse_button_o[5:2] == 4'd0)
    else $error("mouse event carries key code, meta or modifier bits in button");

  a_key_no_mouse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EV_KEY |-> mouse_x_o == 16'd0 && mouse_y_o == 16'd0
    && mouse_button_o == 8'd0 && mouse_action_o == ACT_PRESS)
    else $error("key event carries mouse fields");

  a_action_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mouse_action_o == ACT_PRESS || mouse_action_o == ACT_DRAG
    || mouse_action_o == ACT_RELEASE)
    else $error("illegal mouse action");

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_code_o <= 5'd22)
    else $error("key code out of range");

endmodule

bind csi_key_mouse_decoder csi_kmd_checker u_csi_kmd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .event_kind_o    (event_kind_o),
  .key_code_o      (key_code_o),
  .modifier_bits_o (modifier_bits_o),
  .mouse_x_o       (mouse_x_o),
  .mouse_y_o       (mouse_y_o),
  .mouse_button_o  (mouse_button_o),
  .mouse_action_o  (mouse_action_o)
);
